FILE: hdl/dtq_pkg.sv
`timescale 1ns / 1ps
package dtq_pkg;

    localparam int NUM_TIMERS   = 16;
    localparam int TIME_BITS    = 48;
    localparam int PERIOD_BITS  = 40;
    localparam int MAX_RESULTS  = 16;
    localparam int SLOT_W       = $clog2(NUM_TIMERS);
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
    localparam int ORD_W        = $clog2(MAX_RESULTS);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_SCAN,
        ENG_ACT,
        ENG_UPDATE,
        ENG_EARLY,
        ENG_EMIT
    } eng_state_t;

    typedef struct packed {
        cmd_t                   command;
        logic [3:0]             handle_slot;
        logic [7:0]             handle_generation;
        logic [TIME_BITS-1:0]   deadline;
        logic [PERIOD_BITS-1:0] period;
        logic [TIME_BITS-1:0]   now_time;
    } cmd_rec_t;

    typedef struct packed {
        status_t              status;
        logic [3:0]           assigned_slot;
        logic [7:0]           assigned_generation;
        logic                 earliest_changed;
        logic                 fired;
        logic [3:0]           fired_slot;
        logic [7:0]           fired_generation;
        logic                 next_valid;
        logic [TIME_BITS-1:0] next_deadline;
        logic                 last;
    } result_t;

endpackage

FILE: hdl/deadline_timer_queue_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Width           Contents
// s_axis    in   tdata 152, tuser 2   timer command transactions
// m_axis    out  tdata 80, tuser 2, tlast   result transactions, tlast on final one
//
// The back end scans the 16 slots one per cycle; a tick scans again for each timer
// that it fires, and ends on a final empty scan unless all 16 fire.
// Reset clears all valid bits and generations at once; no sweep.
// The front queue holds two commands, so input is taken while the back end
// works or while a result waits in the output register.
// A stalled m_axis holds its result; the engine waits before writing the next.
module deadline_timer_queue_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [3:0] handle_slot, [11:4] handle_generation, [59:12] deadline,
    // [99:60] period, [147:100] now_time, [151:148] zero
    input  logic [151:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] assigned_slot, [11:4] assigned_generation, [12] earliest_changed,
    // [13] fired, [17:14] fired_slot, [25:18] fired_generation, [26] next_valid,
    // [74:27] next_deadline, [79:75] zero
    output logic [79:0]  m_axis_tdata,
    // [1:0] status
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    dtq_pkg::cmd_rec_t in_rec;
    dtq_pkg::cmd_rec_t q_rec;
    dtq_pkg::result_t  res;
    logic              q_valid;
    logic              q_ready;

    // unpack the command transaction
    always_comb
    begin
        in_rec.command           = dtq_pkg::cmd_t'(s_axis_tuser);
        in_rec.handle_slot       = s_axis_tdata[3:0];
        in_rec.handle_generation = s_axis_tdata[11:4];
        in_rec.deadline          = s_axis_tdata[59:12];
        in_rec.period            = s_axis_tdata[99:60];
        in_rec.now_time          = s_axis_tdata[147:100];
    end

    dtq_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_rec   (in_rec),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_rec    (q_rec)
    );

    dtq_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_rec     (q_rec),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // pack the result transaction
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last;
    assign m_axis_tdata = {5'd0, res.next_deadline, res.next_valid, res.fired_generation,
                           res.fired_slot, res.fired, res.earliest_changed,
                           res.assigned_generation, res.assigned_slot};

endmodule

FILE: hdl/dtq_front.sv
`timescale 1ns / 1ps
// Input side: takes transactions, classifies the command code, queues them.
module dtq_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dtq_pkg::cmd_rec_t  in_rec,
    output logic               q_valid,
    input  logic               q_ready,
    output dtq_pkg::cmd_rec_t  q_rec
);

    dtq_pkg::cmd_rec_t                  mem_reg [dtq_pkg::QUEUE_DEPTH];
    logic [dtq_pkg::QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [dtq_pkg::QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [dtq_pkg::QCNT_W-1:0]         cnt_reg, cnt_next;
    logic                               push, pop;
    dtq_pkg::cmd_rec_t                  cls_rec;

    // unknown codes become an explicit no-op
    always_comb
    begin
        cls_rec = in_rec;
        unique case (in_rec.command)
            dtq_pkg::CMD_ADD, dtq_pkg::CMD_CANCEL, dtq_pkg::CMD_TICK: cls_rec.command = in_rec.command;
            default: cls_rec.command = dtq_pkg::CMD_NONE;
        endcase
    end

    assign in_ready = (cnt_reg != dtq_pkg::QCNT_W'(dtq_pkg::QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_rec    = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == dtq_pkg::QPTR_W'(dtq_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == dtq_pkg::QPTR_W'(dtq_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cls_rec;
        end
    end

endmodule

FILE: hdl/dtq_engine.sv
`timescale 1ns / 1ps
// Back end: slot table, slot-serial scans, result register.
module dtq_engine
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  dtq_pkg::cmd_rec_t  q_rec,
    output logic               res_valid,
    input  logic               res_ready,
    output dtq_pkg::result_t   res
);

    localparam logic [dtq_pkg::SLOT_W-1:0] LAST_IDX = dtq_pkg::SLOT_W'(dtq_pkg::NUM_TIMERS - 1);
    localparam logic [dtq_pkg::TIME_BITS-1:0] TIME_MAX = '1;

    // slot table
    logic                               slot_valid_reg [dtq_pkg::NUM_TIMERS];
    logic [7:0]                         slot_gen_reg   [dtq_pkg::NUM_TIMERS];
    logic [dtq_pkg::TIME_BITS-1:0]      slot_dl_reg    [dtq_pkg::NUM_TIMERS];
    logic [dtq_pkg::PERIOD_BITS-1:0]    slot_per_reg   [dtq_pkg::NUM_TIMERS];
    logic                               picked_reg     [dtq_pkg::NUM_TIMERS];
    logic [3:0]                         ord_slot_reg   [dtq_pkg::MAX_RESULTS];
    logic [7:0]                         ord_gen_reg    [dtq_pkg::MAX_RESULTS];

    dtq_pkg::eng_state_t                state_reg, state_next;
    dtq_pkg::cmd_rec_t                  cur_reg;
    logic [dtq_pkg::SLOT_W-1:0]         idx_reg;
    logic                               any_reg;
    logic [dtq_pkg::TIME_BITS-1:0]      min_reg;
    logic                               free_found_reg;
    logic [dtq_pkg::SLOT_W-1:0]         free_idx_reg;
    logic                               found_reg;
    logic [dtq_pkg::SLOT_W-1:0]         best_idx_reg;
    logic [dtq_pkg::TIME_BITS-1:0]      best_dl_reg;
    logic [7:0]                         best_gen_reg;
    logic [dtq_pkg::CNT_W-1:0]          cnt_reg;
    logic [dtq_pkg::CNT_W-1:0]          k_reg;
    dtq_pkg::status_t                   status_reg;
    logic [3:0]                         aslot_reg;
    logic [7:0]                         agen_reg;
    logic                               changed_reg;
    logic                               out_valid_reg;
    dtq_pkg::result_t                   out_reg;

    // single read port into the table
    logic [dtq_pkg::SLOT_W-1:0]         rd_idx;
    logic                               rd_valid;
    logic [7:0]                         rd_gen;
    logic [dtq_pkg::TIME_BITS-1:0]      rd_dl;
    logic [dtq_pkg::PERIOD_BITS-1:0]    rd_per;
    logic [dtq_pkg::TIME_BITS:0]        rearm_sum;
    logic [dtq_pkg::TIME_BITS-1:0]      rearm_dl;
    logic                               last_idx;
    logic                               out_free;
    logic                               handle_hit;
    logic                               tick_elig;
    logic                               emit_last;
    logic                               cnt_full;
    logic [dtq_pkg::SLOT_W-1:0]         hs_idx;

    assign hs_idx   = dtq_pkg::SLOT_W'(cur_reg.handle_slot);
    assign last_idx = (idx_reg == LAST_IDX);
    assign out_free = !out_valid_reg || res_ready;

    always_comb
    begin
        unique case (state_reg)
            dtq_pkg::ENG_ACT:
            begin
                rd_idx = (cur_reg.command == dtq_pkg::CMD_CANCEL) ? hs_idx : free_idx_reg;
            end
            default: rd_idx = idx_reg;
        endcase
    end

    assign rd_valid  = slot_valid_reg[rd_idx];
    assign rd_gen    = slot_gen_reg[rd_idx];
    assign rd_dl     = slot_dl_reg[rd_idx];
    assign rd_per    = slot_per_reg[rd_idx];
    assign rearm_sum = {1'b0, cur_reg.now_time} + (dtq_pkg::TIME_BITS + 1)'(rd_per);
    assign rearm_dl  = rearm_sum[dtq_pkg::TIME_BITS] ? TIME_MAX
                                                     : rearm_sum[dtq_pkg::TIME_BITS-1:0];
    assign tick_elig = rd_valid && !picked_reg[rd_idx] && (rd_dl <= cur_reg.now_time);
    assign handle_hit = (32'(cur_reg.handle_slot) < dtq_pkg::NUM_TIMERS) && rd_valid
                        && (rd_gen == cur_reg.handle_generation);
    assign emit_last = (cnt_reg == '0) || (k_reg + 1'b1 == cnt_reg);
    assign cnt_full  = (cnt_reg + 1'b1 == dtq_pkg::CNT_W'(dtq_pkg::MAX_RESULTS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dtq_pkg::ENG_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_rec.command)
                        dtq_pkg::CMD_ADD, dtq_pkg::CMD_TICK: state_next = dtq_pkg::ENG_SCAN;
                        dtq_pkg::CMD_CANCEL:                 state_next = dtq_pkg::ENG_ACT;
                        default:                             state_next = dtq_pkg::ENG_EARLY;
                    endcase
                end
            end
            dtq_pkg::ENG_SCAN:
            begin
                if (last_idx)
                begin
                    state_next = dtq_pkg::ENG_ACT;
                end
            end
            dtq_pkg::ENG_ACT:
            begin
                if (cur_reg.command == dtq_pkg::CMD_TICK)
                begin
                    state_next = (found_reg && !cnt_full) ? dtq_pkg::ENG_SCAN
                                                          : dtq_pkg::ENG_UPDATE;
                end
                else
                begin
                    state_next = dtq_pkg::ENG_EARLY;
                end
            end
            dtq_pkg::ENG_UPDATE:
            begin
                if (last_idx)
                begin
                    state_next = dtq_pkg::ENG_EARLY;
                end
            end
            dtq_pkg::ENG_EARLY:
            begin
                if (last_idx)
                begin
                    state_next = dtq_pkg::ENG_EMIT;
                end
            end
            dtq_pkg::ENG_EMIT:
            begin
                if (out_free && emit_last)
                begin
                    state_next = dtq_pkg::ENG_IDLE;
                end
            end
            default: state_next = dtq_pkg::ENG_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_ready = (state_reg == dtq_pkg::ENG_IDLE);
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtq_pkg::ENG_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control and slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            cnt_reg        <= '0;
            k_reg          <= '0;
            found_reg      <= 1'b0;
            any_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < dtq_pkg::NUM_TIMERS; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
                slot_gen_reg[i]   <= '0;
                picked_reg[i]     <= 1'b0;
            end
        end
        else
        begin
            if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                dtq_pkg::ENG_IDLE:
                begin
                    idx_reg        <= '0;
                    cnt_reg        <= '0;
                    k_reg          <= '0;
                    found_reg      <= 1'b0;
                    any_reg        <= 1'b0;
                    free_found_reg <= 1'b0;
                    for (int i = 0; i < dtq_pkg::NUM_TIMERS; i++)
                    begin
                        picked_reg[i] <= 1'b0;
                    end
                end
                dtq_pkg::ENG_SCAN:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (cur_reg.command == dtq_pkg::CMD_ADD)
                    begin
                        if (rd_valid)
                        begin
                            any_reg <= 1'b1;
                        end
                        else if (!free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                        end
                    end
                    else if (tick_elig && (!found_reg || rd_dl < best_dl_reg))
                    begin
                        found_reg <= 1'b1;
                    end
                end
                dtq_pkg::ENG_ACT:
                begin
                    idx_reg <= '0;
                    unique case (cur_reg.command)
                        dtq_pkg::CMD_ADD:
                        begin
                            if (free_found_reg)
                            begin
                                slot_valid_reg[free_idx_reg] <= 1'b1;
                                slot_gen_reg[free_idx_reg]   <= rd_gen + 8'd1;
                            end
                            any_reg <= 1'b0;
                        end
                        dtq_pkg::CMD_CANCEL:
                        begin
                            if (handle_hit)
                            begin
                                slot_valid_reg[hs_idx] <= 1'b0;
                            end
                            any_reg <= 1'b0;
                        end
                        default:
                        begin
                            found_reg <= 1'b0;
                            if (found_reg)
                            begin
                                picked_reg[best_idx_reg] <= 1'b1;
                                cnt_reg                  <= cnt_reg + 1'b1;
                            end
                        end
                    endcase
                end
                dtq_pkg::ENG_UPDATE:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (picked_reg[idx_reg] && (rd_per == '0))
                    begin
                        slot_valid_reg[idx_reg] <= 1'b0;
                    end
                    any_reg <= 1'b0;
                end
                dtq_pkg::ENG_EARLY:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (rd_valid)
                    begin
                        any_reg <= 1'b1;
                    end
                end
                dtq_pkg::ENG_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        k_reg         <= k_reg + 1'b1;
                    end
                end
                default:
                begin
                    idx_reg <= '0;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            dtq_pkg::ENG_IDLE:
            begin
                cur_reg     <= q_rec;
                // defaults for commands that skip the act step
                status_reg  <= dtq_pkg::STS_OK;
                aslot_reg   <= '0;
                agen_reg    <= '0;
                changed_reg <= 1'b0;
            end
            dtq_pkg::ENG_SCAN:
            begin
                if (cur_reg.command == dtq_pkg::CMD_ADD)
                begin
                    if (rd_valid && (!any_reg || rd_dl < min_reg))
                    begin
                        min_reg <= rd_dl;
                    end
                    if (!rd_valid && !free_found_reg)
                    begin
                        free_idx_reg <= idx_reg;
                    end
                end
                else if (tick_elig && (!found_reg || rd_dl < best_dl_reg))
                begin
                    best_idx_reg <= idx_reg;
                    best_dl_reg  <= rd_dl;
                    best_gen_reg <= rd_gen;
                end
            end
            dtq_pkg::ENG_ACT:
            begin
                status_reg  <= dtq_pkg::STS_OK;
                aslot_reg   <= '0;
                agen_reg    <= '0;
                changed_reg <= 1'b0;
                unique case (cur_reg.command)
                    dtq_pkg::CMD_ADD:
                    begin
                        if (free_found_reg)
                        begin
                            slot_dl_reg[free_idx_reg]  <= cur_reg.deadline;
                            slot_per_reg[free_idx_reg] <= cur_reg.period;
                            aslot_reg   <= 4'(free_idx_reg);
                            agen_reg    <= rd_gen + 8'd1;
                            changed_reg <= !any_reg || (cur_reg.deadline < min_reg);
                        end
                        else
                        begin
                            status_reg <= dtq_pkg::STS_FULL;
                        end
                    end
                    dtq_pkg::CMD_CANCEL:
                    begin
                        if (!handle_hit)
                        begin
                            status_reg <= dtq_pkg::STS_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        if (found_reg)
                        begin
                            ord_slot_reg[cnt_reg[dtq_pkg::ORD_W-1:0]] <= 4'(best_idx_reg);
                            ord_gen_reg[cnt_reg[dtq_pkg::ORD_W-1:0]]  <= best_gen_reg;
                        end
                    end
                endcase
            end
            dtq_pkg::ENG_UPDATE:
            begin
                if (picked_reg[idx_reg] && (rd_per != '0))
                begin
                    slot_dl_reg[idx_reg] <= rearm_dl;
                end
            end
            dtq_pkg::ENG_EARLY:
            begin
                if (rd_valid && (!any_reg || rd_dl < min_reg))
                begin
                    min_reg <= rd_dl;
                end
            end
            dtq_pkg::ENG_EMIT:
            begin
                if (out_free)
                begin
                    out_reg.status              <= status_reg;
                    out_reg.assigned_slot       <= aslot_reg;
                    out_reg.assigned_generation <= agen_reg;
                    out_reg.earliest_changed    <= changed_reg;
                    out_reg.fired               <= (cnt_reg != '0);
                    out_reg.fired_slot          <= (cnt_reg != '0) ?
                                                   ord_slot_reg[k_reg[dtq_pkg::ORD_W-1:0]] : '0;
                    out_reg.fired_generation    <= (cnt_reg != '0) ?
                                                   ord_gen_reg[k_reg[dtq_pkg::ORD_W-1:0]] : '0;
                    out_reg.next_valid          <= any_reg;
                    out_reg.next_deadline       <= any_reg ? min_reg : '0;
                    out_reg.last                <= emit_last;
                end
            end
            default:
            begin
                cur_reg <= cur_reg;
            end
        endcase
    end

endmodule

FILE: hdl/dtq_checker.sv
`timescale 1ns / 1ps
module dtq_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [79:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // a full table gives one plain result
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == dtq_pkg::STS_FULL) |->
        m_axis_tlast && !m_axis_tdata[13] && (m_axis_tdata[11:0] == 12'd0))
        else $error("full status with payload");

    // fired results only come with ok status
    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[13] |-> (m_axis_tuser == dtq_pkg::STS_OK))
        else $error("fired with error status");

    // empty queue reports zero deadline
    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[26] |-> (m_axis_tdata[74:27] == 48'd0))
        else $error("deadline without pending timer");

endmodule

bind deadline_timer_queue_core dtq_checker u_dtq_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
